// File: design/pss_pkg.sv
// Package for the parity split sorter: transaction types, queue entry type
// and the ordering key function. Depends on nothing.
`timescale 1ns / 1ps
package pss_pkg;

   typedef struct packed {
      logic signed [31:0] value;
      logic               is_final;
   } req_type;

   typedef struct packed {
      logic signed [31:0] sorted_value;
      logic               is_last;
      logic               overflow;
   } rsp_type;

   // One classified element travelling from the front to the back.
   typedef struct packed {
      logic signed [31:0] value;
      logic               is_final;
      logic               store;
      logic               overflow;
   } entry_type;

   localparam int KEY_W = 33;

   // Ascending key order gives evens ascending, then odds descending.
   function automatic logic [KEY_W-1:0] sort_key(input logic [31:0] v);
      logic [31:0] flip;
      flip = v ^ 32'h8000_0000;
      return v[0] ? {1'b1, ~flip} : {1'b0, flip};
   endfunction

endpackage

// File: design/parity_split_sorter_top.sv
// Top level of the parity split sorter: front, queue and back end.
// Depends on pss_pkg, pss_front, pss_queue and pss_back.
// Input: one transaction per cycle while the back end collects a run; while a run
// drains, the input stalls as soon as two transactions wait in the queue.
// Once the prior run has left, the final transaction starts the drain from the queue;
// results leave one per cycle while rsp_stall is low. Reset: synchronous, active high.
`timescale 1ns / 1ps
module parity_split_sorter_top #(
   parameter int CAPACITY = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pss_pkg::rsp_type rsp_data
);
   // The front tags each element as stored or dropped against the capacity,
   // so the back only needs to sort what it is handed.
   logic               push, queue_full, pop, head_valid;
   pss_pkg::entry_type push_entry, head_entry;

   pss_front #(.CAPACITY(CAPACITY)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .push(push), .push_entry(push_entry), .queue_full(queue_full)
   );

   // The queue holds up to two transactions, so the front keeps accepting
   // until the queue is full while the back drains a run.
   pss_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_entry(push_entry), .full(queue_full),
      .pop(pop), .head_valid(head_valid), .head_entry(head_entry)
   );

   // The cell chain keeps the run in output order at all times.
   pss_back #(.CAPACITY(CAPACITY)) u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head_entry(head_entry), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );
endmodule

// File: design/pss_front.sv
// Front end of the parity split sorter: accepts transactions, counts the run
// and marks each element as stored or dropped. Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_front #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  pss_pkg::req_type    req_data,
   output logic                push,
   output pss_pkg::entry_type  push_entry,
   input  logic                queue_full
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic             room;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign room      = count_ff < CNT_W'(CAPACITY);

   always_comb begin
      push_entry.value    = req_data.value;
      push_entry.is_final = req_data.is_final;
      push_entry.store    = room;
      push_entry.overflow = dropped_ff || !room;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (push) begin
         if (req_data.is_final) begin
            count_in   = '0;
            dropped_in = 1'b0;
         end else if (room) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            dropped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end
endmodule

// File: design/pss_queue.sv
// Two-entry queue between the front and back of the parity split sorter.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pss_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output pss_pkg::entry_type  head_entry
);
   pss_pkg::entry_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   assign full       = fill_ff == 2'd2;
   assign head_valid = fill_ff != 2'd0;
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end
endmodule

// File: design/pss_back.sv
// Back end of the parity split sorter: an insertion-sort cell chain that
// takes one element a cycle while not draining, then shifts the run out. Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_back #(
   parameter int CAPACITY = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  pss_pkg::entry_type  head_entry,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output pss_pkg::rsp_type    rsp_data
);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [31:0]          cell_data_ff  [CAPACITY];
   logic [31:0]          cell_data_in  [CAPACITY];
   logic [CAPACITY-1:0]  cell_valid_ff, cell_valid_in;
   logic [CAPACITY-1:0]  lt;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     remain_ff, remain_in;
   logic                 draining_ff, draining_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   pss_pkg::rsp_type     rsp_data_ff, rsp_data_in;
   logic                 ins, drain_go;
   logic [pss_pkg::KEY_W-1:0] new_key;

   assign pop      = head_valid && !draining_ff;
   assign ins      = pop && head_entry.store;
   assign drain_go = draining_ff && (!rsp_valid_ff || !rsp_stall);
   assign new_key  = pss_pkg::sort_key(head_entry.value);

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         always_comb begin
            lt[g] = !cell_valid_ff[g] || (new_key < pss_pkg::sort_key(cell_data_ff[g]));
            cell_data_in[g]  = cell_data_ff[g];
            cell_valid_in[g] = cell_valid_ff[g];
            if (drain_go) begin
               if (g < CAPACITY - 1) begin
                  cell_data_in[g]  = cell_data_ff[(g + 1) % CAPACITY];
                  cell_valid_in[g] = cell_valid_ff[(g + 1) % CAPACITY];
               end else begin
                  cell_valid_in[g] = 1'b0;
               end
            end else if (ins && lt[g]) begin
               if (g == 0 || !lt[(g + CAPACITY - 1) % CAPACITY]) begin
                  cell_data_in[g]  = head_entry.value;
                  cell_valid_in[g] = 1'b1;
               end else begin
                  cell_data_in[g]  = cell_data_ff[(g + CAPACITY - 1) % CAPACITY];
                  cell_valid_in[g] = cell_valid_ff[(g + CAPACITY - 1) % CAPACITY];
               end
            end
         end

         always_ff @(posedge clock) begin
            cell_data_ff[g] <= cell_data_in[g];
         end
      end
   endgenerate

   always_comb begin
      count_in     = ins ? count_ff + CNT_W'(1) : count_ff;
      remain_in    = remain_ff;
      draining_in  = draining_ff;
      ovf_in       = ovf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pop && head_entry.is_final) begin
         draining_in = 1'b1;
         remain_in   = count_in;
         ovf_in      = head_entry.overflow;
         count_in    = '0;
      end
      if (drain_go) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.sorted_value = cell_data_ff[0];
         rsp_data_in.is_last      = remain_ff == CNT_W'(1);
         rsp_data_in.overflow     = ovf_ff;
         remain_in                = remain_ff - CNT_W'(1);
         if (remain_ff == CNT_W'(1)) begin
            draining_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      remain_ff   <= remain_in;
      ovf_ff      <= ovf_in;
      if (reset) begin
         cell_valid_ff <= '0;
         count_ff      <= '0;
         draining_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cell_valid_ff <= cell_valid_in;
         count_ff      <= count_in;
         draining_ff   <= draining_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

// File: design/pss_checker.sv
// Port checker for the parity split sorter, bound to the top level.
// Depends on pss_pkg and parity_split_sorter_top.
`timescale 1ns / 1ps
module pss_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pss_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("input stalled right after reset");
endmodule

bind parity_split_sorter_top pss_checker u_pss_checker (
   .clock(clock), .reset(reset), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);
